// ----- rtl/gmr_pkg.sv -----
`timescale 1ns / 1ps

package gmr_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int DimRegW  = 7;

  localparam logic [DimRegW-1:0] RowCountReset = 7'd64;
  localparam logic [DimRegW-1:0] ColCountReset = 7'd64;

  localparam logic [7:0] CharPath  = 8'h78;  // 'x'
  localparam logic [7:0] CharExit  = 8'h73;  // 's'
  localparam logic [7:0] CharStart = 8'h65;  // 'e'

  typedef enum logic [1:0] {
    CODE_BLOCKED = 2'd0,
    CODE_PATH    = 2'd1,
    CODE_EXIT    = 2'd2,
    CODE_START   = 2'd3
  } cell_code_e;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       last_cell;
  } in_item_t;

  typedef struct packed {
    logic exit_found;
    logic start_missing;
  } out_item_t;

  typedef struct packed {
    logic [DimRegW-1:0] row_count;
    logic [DimRegW-1:0] col_count;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic last_load;
    logic prep;
    logic check;
    logic div_step;
    logic start_take;
    logic cand_take;
    logic visit;
    logic dir_inc;
    logic pop;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic missing;
    logic div_done;
    logic cand_ok;
    logic dir_last;
    logic stack_empty;
    logic out_busy;
  } dp_status_t;

  function automatic cell_code_e code_of(logic [7:0] ch);
    cell_code_e code;
    code = CODE_BLOCKED;
    if (ch == CharPath) begin
      code = CODE_PATH;
    end else if (ch == CharExit) begin
      code = CODE_EXIT;
    end else if (ch == CharStart) begin
      code = CODE_START;
    end
    return code;
  endfunction

endpackage

// ----- rtl/gmr_regs.sv -----
`timescale 1ns / 1ps

module gmr_regs import gmr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_e;

  logic [DimRegW-1:0] row_count_q;
  logic [DimRegW-1:0] col_count_q;
  logic               wr_en;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountReset;
      col_count_q <= ColCountReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW_COUNT: row_count_q <= pwdata[DimRegW-1:0];
        REG_COL_COUNT: col_count_q <= pwdata[DimRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ROW_COUNT: prdata[DimRegW-1:0] = row_count_q;
      REG_COL_COUNT: prdata[DimRegW-1:0] = col_count_q;
      default: ;
    endcase
  end

  assign cfg_o.row_count = row_count_q;
  assign cfg_o.col_count = col_count_q;

endmodule

// ----- rtl/gmr_ctrl.sv -----
`timescale 1ns / 1ps

module gmr_ctrl import gmr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PREP,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_POP,
    S_DIR,
    S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_LOAD);
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.last_load = 1'b1;
            state_d         = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.missing ? S_DONE : S_DIV;
      end
      S_DIV: begin
        // split the start index into row and column
        if (status_i.div_done) begin
          cmd_o.start_take = 1'b1;
          state_d          = S_TEST;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_TEST: begin
        cmd_o.visit = 1'b1;
        if (status_i.dir_last) begin
          state_d = S_POP;
        end else begin
          cmd_o.dir_inc = 1'b1;
          state_d       = S_DIR;
        end
      end
      S_POP: begin
        if (status_i.stack_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_DIR;
        end
      end
      S_DIR: begin
        if (status_i.cand_ok) begin
          cmd_o.cand_take = 1'b1;
          state_d         = S_TEST;
        end else if (status_i.dir_last) begin
          state_d = S_POP;
        end else begin
          cmd_o.dir_inc = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

// ----- rtl/gmr_datapath.sv -----
`timescale 1ns / 1ps

module gmr_datapath import gmr_pkg::*; #(
  parameter int MAX_ROWS = MaxRows,
  parameter int MAX_COLS = MaxCols
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  in_item_t   in_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o
);

  localparam int Cap    = MAX_ROWS * MAX_COLS;
  localparam int IdxW   = (Cap > 1) ? $clog2(Cap) : 1;
  localparam int CntW   = $clog2(Cap + 1);
  localparam int RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RDimW  = $clog2(MAX_ROWS + 1);
  localparam int CDimW  = $clog2(MAX_COLS + 1);
  localparam int ProdW  = RDimW + CDimW;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } node_t;

  cell_code_e cell_mem [Cap];
  node_t      stack_mem [Cap];

  logic [CntW-1:0]  load_index_q;
  logic             start_seen_q;
  logic [IdxW-1:0]  start_cell_q;
  logic [CntW-1:0]  sp_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [RDimW-1:0] rows_q;
  logic [CDimW-1:0] cols_q;
  logic [RDimW-1:0] rows_clamp;
  logic [CDimW-1:0] cols_clamp;
  logic [CntW-1:0]  used_q;
  logic [ProdW-1:0] prod;
  logic [IdxW-1:0]  rem_q;
  logic [RowW-1:0]  srow_q;
  logic             exit_q;
  logic             missing_q;
  dir_e             dir_q;
  node_t            cand_q;
  cell_code_e       cell_rd_q;
  node_t            stack_rd_q;

  cell_code_e       in_code;
  logic             load_wr;
  logic             cell_open;
  logic             push_ok;
  logic             cell_we;
  logic [IdxW-1:0]  cell_waddr;
  cell_code_e       cell_wdata;
  logic             cell_re;
  logic [IdxW-1:0]  cell_raddr;
  node_t            cand;
  logic [CntW-1:0]  nidx;
  logic             step_ok;
  logic             missing;
  logic             div_done;

  assign in_code   = code_of(in_data_i.cell_char);
  assign load_wr   = cmd_i.load && (load_index_q < CntW'(Cap));
  assign cell_open = (cell_rd_q != CODE_BLOCKED);
  assign push_ok   = cmd_i.visit && cell_open && (sp_q < CntW'(Cap));

  // dimensions: zero acts as one, above the maximum saturates
  always_comb begin
    if (cfg_i.row_count == '0) begin
      rows_clamp = RDimW'(1);
    end else if (int'(cfg_i.row_count) > MAX_ROWS) begin
      rows_clamp = RDimW'(MAX_ROWS);
    end else begin
      rows_clamp = RDimW'(cfg_i.row_count);
    end
    if (cfg_i.col_count == '0) begin
      cols_clamp = CDimW'(1);
    end else if (int'(cfg_i.col_count) > MAX_COLS) begin
      cols_clamp = CDimW'(MAX_COLS);
    end else begin
      cols_clamp = CDimW'(cfg_i.col_count);
    end
  end

  assign prod     = ProdW'(rows_q) * ProdW'(cols_q);
  assign missing  = !start_seen_q || (CntW'(start_cell_q) >= used_q);
  assign div_done = (CntW'(rem_q) < CntW'(cols_q));

  // neighbor of the popped cell in the current direction
  always_comb begin
    cand    = stack_rd_q;
    nidx    = CntW'(stack_rd_q.idx);
    step_ok = 1'b0;
    case (dir_q)
      DIR_UP: begin
        step_ok  = (stack_rd_q.row != '0);
        cand.row = stack_rd_q.row - 1'b1;
        nidx     = CntW'(stack_rd_q.idx) - CntW'(cols_q);
      end
      DIR_RIGHT: begin
        step_ok  = ((CDimW'(stack_rd_q.col) + 1'b1) < cols_q);
        cand.col = stack_rd_q.col + 1'b1;
        nidx     = CntW'(stack_rd_q.idx) + 1'b1;
      end
      DIR_DOWN: begin
        step_ok  = ((RDimW'(stack_rd_q.row) + 1'b1) < rows_q);
        cand.row = stack_rd_q.row + 1'b1;
        nidx     = CntW'(stack_rd_q.idx) + CntW'(cols_q);
      end
      DIR_LEFT: begin
        step_ok  = (stack_rd_q.col != '0);
        cand.col = stack_rd_q.col - 1'b1;
        nidx     = CntW'(stack_rd_q.idx) - 1'b1;
      end
      default: ;
    endcase
    cand.idx = IdxW'(nidx);
  end

  // cell store ports
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cand_q.idx;
    cell_wdata = CODE_BLOCKED;
    if (load_wr) begin
      cell_we    = 1'b1;
      cell_waddr = load_index_q[IdxW-1:0];
      cell_wdata = in_code;
    end else if (cmd_i.visit && cell_open) begin
      cell_we = 1'b1;
    end
    cell_re    = cmd_i.start_take || cmd_i.cand_take;
    cell_raddr = cmd_i.start_take ? start_cell_q : cand.idx;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      stack_mem[sp_q[IdxW-1:0]] <= cand_q;
    end
    if (cmd_i.pop) begin
      stack_rd_q <= stack_mem[IdxW'(sp_q - 1'b1)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_index_q <= '0;
      start_seen_q <= 1'b0;
      sp_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_wr) begin
        load_index_q <= load_index_q + 1'b1;
        if ((in_code == CODE_START) && !start_seen_q) begin
          start_seen_q <= 1'b1;
        end
      end
      if (push_ok) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - 1'b1;
      end
      if (cmd_i.finish) begin
        load_index_q <= '0;
        start_seen_q <= 1'b0;
        sp_q         <= '0;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr && (in_code == CODE_START) && !start_seen_q) begin
      start_cell_q <= load_index_q[IdxW-1:0];
    end
    if (cmd_i.last_load) begin
      rows_q <= rows_clamp;
      cols_q <= cols_clamp;
    end
    if (cmd_i.prep) begin
      used_q <= (prod < ProdW'(load_index_q)) ? CntW'(prod) : load_index_q;
      rem_q  <= start_cell_q;
      srow_q <= '0;
      exit_q <= 1'b0;
    end
    if (cmd_i.check) begin
      missing_q <= missing;
    end
    if (cmd_i.div_step) begin
      rem_q  <= IdxW'(CntW'(rem_q) - CntW'(cols_q));
      srow_q <= srow_q + 1'b1;
    end
    if (cmd_i.start_take) begin
      cand_q.idx <= start_cell_q;
      cand_q.row <= srow_q;
      cand_q.col <= ColW'(rem_q);
      dir_q      <= DIR_LEFT;
    end
    if (cmd_i.cand_take) begin
      cand_q <= cand;
    end
    if (cmd_i.pop) begin
      dir_q <= DIR_UP;
    end
    if (cmd_i.dir_inc) begin
      dir_q <= dir_e'(dir_q + 2'd1);
    end
    if (cmd_i.visit && (cell_rd_q == CODE_EXIT)) begin
      exit_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      out_q.exit_found    <= exit_q && !missing_q;
      out_q.start_missing <= missing_q;
    end
  end

  assign status_o.missing     = missing;
  assign status_o.div_done    = div_done;
  assign status_o.cand_ok     = step_ok && (nidx < used_q);
  assign status_o.dir_last    = (dir_q == DIR_LEFT);
  assign status_o.stack_empty = (sp_q == '0);
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CntW'(Cap))
    else $error("stack pointer beyond capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (sp_q != '0))
    else $error("pop from empty stack");

  a_start_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_take |-> (start_seen_q && (CntW'(start_cell_q) < used_q)))
    else $error("search started from a start outside the grid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites one not yet transferred");

endmodule

// ----- rtl/grid_maze_reachability.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (cell_char, last_cell)
// out      output     out_valid_o / out_ready_i out_data_o (exit_found, start_missing)
// cfg      input      psel/penable/pwrite      paddr, pwdata, prdata (row_count, col_count)
//
// Cells load one per cycle into the cell store while the input is open; the last cell starts the search.
// Search: the start index is split into row and column by repeated subtraction, then each cell
// reached is popped and its four neighbors stepped, one store check per neighbor in the grid.
// Input stalls during the search; it reopens once the result is in the output register.
// Reset clears counters and handshake state; the cell store and stack are not cleared.
// A stalled result holds in the output register while the next grid loads.
module grid_maze_reachability import gmr_pkg::*; #(
  parameter int MAX_ROWS = MaxRows,
  parameter int MAX_COLS = MaxCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  gmr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_cell),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gmr_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- sim/tb_grid_maze_reachability.sv -----
`timescale 1ns / 1ps

module tb_grid_maze_reachability;
  import gmr_pkg::*;

  localparam int CellCap = MaxRows * MaxCols;
  localparam logic [ApbAddrW-1:0] AddrRowCount = 3'd0;
  localparam logic [ApbAddrW-1:0] AddrColCount = 3'd4;
  localparam logic [7:0] CharWall = 8'h2e;
  localparam int RandomCells = 560;
  localparam int QuietTail = 120;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // maze shadow used to work out each verdict
  cell_code_e         maze_codes [CellCap];
  int                 cells_loaded = 0;
  int                 start_index = 0;
  bit                 start_known = 1'b0;
  logic [DimRegW-1:0] row_count_shadow = RowCountReset;
  logic [DimRegW-1:0] col_count_shadow = ColCountReset;
  out_item_t          verdict_q [$];

  logic [7:0] grid_chars [$];
  bit         idle_en = 1'b1;
  int         hold_cycles = 0;
  int         fail_count = 0;
  int         cells_accepted = 0;
  int         grids_checked = 0;
  int         exits_seen = 0;
  int         missing_seen = 0;

  grid_maze_reachability uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int dim_in_use(logic [DimRegW-1:0] v, int top);
    if (v == 0) return 1;
    return (int'(v) > top) ? top : int'(v);
  endfunction

  function automatic void predict_cell(in_item_t item);
    cell_code_e code;
    out_item_t  verdict;
    int         rows, cols, used, depth, cur, r, c, nr, nc, ni;
    int         trail [CellCap];
    case (item.cell_char)
      CharPath:  code = CODE_PATH;
      CharExit:  code = CODE_EXIT;
      CharStart: code = CODE_START;
      default:   code = CODE_BLOCKED;
    endcase
    // drop cells once the store is full
    if (cells_loaded < CellCap) begin
      maze_codes[cells_loaded] = code;
      if (code == CODE_START && !start_known) begin
        start_index = cells_loaded;
        start_known = 1'b1;
      end
      cells_loaded++;
    end
    if (item.last_cell) begin
      rows = dim_in_use(row_count_shadow, MaxRows);
      cols = dim_in_use(col_count_shadow, MaxCols);
      used = rows * cols;
      if (used > cells_loaded) used = cells_loaded;
      verdict = '0;
      verdict.start_missing = !start_known || start_index >= used;
      if (!verdict.start_missing) begin
        // claim a cell when it goes on the trail so each one goes on once
        maze_codes[start_index] = CODE_BLOCKED;
        trail[0] = start_index;
        depth = 1;
        while (depth > 0) begin
          depth--;
          cur = trail[depth];
          r = cur / cols;
          c = cur % cols;
          for (int k = 0; k < 4; k++) begin
            nr = r + int'(k == 2) - int'(k == 0);
            nc = c + int'(k == 1) - int'(k == 3);
            if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
              ni = nr * cols + nc;
              if (ni < used && maze_codes[ni] != CODE_BLOCKED) begin
                if (maze_codes[ni] == CODE_EXIT) verdict.exit_found = 1'b1;
                maze_codes[ni] = CODE_BLOCKED;
                trail[depth] = ni;
                depth++;
              end
            end
          end
        end
      end
      verdict_q = {verdict_q, verdict};
      cells_loaded = 0;
      start_index = 0;
      start_known = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_cell(in_data_i);
      cells_accepted++;
    end
  end

  always @(posedge clk_i) begin : check_verdicts
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %b",
                 $time, out_data_o);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.exit_found !== want.exit_found) begin
          $display("%0t: exit_found mismatch: expected %b, actual %b",
                   $time, want.exit_found, out_data_o.exit_found);
          fail_count++;
        end
        if (out_data_o.start_missing !== want.start_missing) begin
          $display("%0t: start_missing mismatch: expected %b, actual %b",
                   $time, want.start_missing, out_data_o.start_missing);
          fail_count++;
        end
        grids_checked++;
        if (want.exit_found) exits_seen++;
        if (want.start_missing) missing_seen++;
      end
    end
  end

  // result side: long hold on request, else random stall bursts
  initial begin : drive_result_ready
    int gap;
    gap = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 16) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_cell(input logic [7:0] ch, input logic last);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= '{cell_char: ch, last_cell: last};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_grid();
    foreach (grid_chars[i]) send_cell(grid_chars[i], i == grid_chars.size() - 1);
  endtask

  // drop valid, let every verdict arrive, then give the search time to wind down
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ApbAddrW-1:0] addr, input logic [DimRegW-1:0] value);
    logic [ApbDataW-1:0] word;
    word = $urandom();
    word[DimRegW-1:0] = value;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == AddrRowCount) row_count_shadow = value;
    else col_count_shadow = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_dims(input int rows, input int cols);
    settle();
    write_reg(AddrRowCount, DimRegW'(rows));
    write_reg(AddrColCount, DimRegW'(cols));
  endtask

  // tidy grids are about half open path, with exits, walls and a start in most; others are raw bytes
  task automatic fill_grid(input int cell_total, input bit tidy);
    logic [7:0] ch;
    grid_chars.delete();
    for (int i = 0; i < cell_total; i++) begin
      if (!tidy) begin
        ch = 8'($urandom_range(0, 255));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: ch = CharPath;
          5:             ch = CharExit;
          6:             ch = 8'($urandom_range(0, 255));
          default:       ch = CharWall;
        endcase
      end
      grid_chars = {grid_chars, ch};
    end
    if (tidy && $urandom_range(0, 9) != 0)
      grid_chars[$urandom_range(0, cell_total - 1)] = CharStart;
  endtask

  task automatic test_basic_paths();
    set_dims(2, 2);
    grid_chars = '{CharStart, CharExit, CharWall, CharWall};
    send_grid();
    grid_chars = '{CharStart, CharWall, CharWall, CharExit};
    send_grid();
    grid_chars = '{CharPath, CharExit, 8'h00, 8'hff};
    send_grid();
  endtask

  task automatic test_ragged_grids();
    set_dims(2, 2);
    // too few cells: search covers only what was loaded
    grid_chars = '{CharExit, CharStart};
    send_grid();
    // start lands past the grid in use
    grid_chars = '{CharPath, CharPath, CharPath, CharExit, CharStart};
    send_grid();
  endtask

  task automatic test_dim_clamp();
    set_dims(0, 127);
    grid_chars = '{CharStart, CharExit};
    send_grid();
    set_dims(127, 0);
    grid_chars = '{CharExit, CharStart};
    send_grid();
    set_dims(1, 1);
    grid_chars = '{CharStart};
    send_grid();
  endtask

  task automatic test_result_backpressure();
    set_dims(3, 3);
    hold_cycles = 2000;
    repeat (4) begin
      fill_grid(9, 1'b1);
      send_grid();
    end
  endtask

  task automatic test_random_mazes();
    int rows, cols, cell_total, shape, sent;
    sent = 0;
    while (sent < RandomCells) begin
      if ($urandom_range(0, 7) == 0) begin
        rows = $urandom_range(0, 127);
        cols = $urandom_range(0, 127);
      end else begin
        rows = $urandom_range(0, 7);
        cols = $urandom_range(0, 7);
      end
      set_dims(rows, cols);
      idle_en = (sent < RandomCells - QuietTail) && $urandom_range(0, 3) != 0;
      repeat ($urandom_range(2, 5)) begin
        cell_total = dim_in_use(DimRegW'(rows), MaxRows) * dim_in_use(DimRegW'(cols), MaxCols);
        if (cell_total > 40) cell_total = 40;
        shape = $urandom_range(0, 9);
        if (shape == 7) cell_total = $urandom_range(1, cell_total);
        else if (shape == 8) cell_total += $urandom_range(1, 4);
        fill_grid(cell_total, shape != 9);
        send_grid();
        sent += cell_total;
      end
    end
    idle_en = 1'b0;
  endtask

  initial begin : run_regression
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_paths();
    test_ragged_grids();
    test_dim_clamp();
    test_result_backpressure();
    test_random_mazes();
    settle();
    $display("Loaded %0d cells and checked %0d search verdicts", cells_accepted, grids_checked);
    $display("(%0d with an exit reached, %0d with no usable start)", exits_seen, missing_seen);
    if (fail_count == 0) begin
      $display("grid_maze_reachability regression: pass");
    end else begin
      $display("grid_maze_reachability regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("grid_maze_reachability regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gmr_pkg.sv
rtl/gmr_regs.sv
rtl/gmr_ctrl.sv
rtl/gmr_datapath.sv
rtl/grid_maze_reachability.sv
sim/tb_grid_maze_reachability.sv
